@@ hw/rtl/icc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner package
// Shared widths, constants, payload types, queue entry and back-end states.
// ----------------------------------------------------------------------------
package icc_pkg;

   localparam int CHANNELS_DEFAULT = 5;
   localparam int HISTORY_DEPTH    = 5;
   localparam int ADC_BITS         = 10;

   localparam int SAMPLE_W = 10;
   localparam int USED_W   = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam int CH_W     = 3;
   localparam int LEVEL_W  = 15;
   localparam int SUM3_W   = 12;
   localparam int WSUM_W   = 14;
   localparam int THR_W    = SAMPLE_W + 1;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << USED_W) - 33'd1);
   localparam logic [SAMPLE_W-1:0] MAX_RESET   = SAMPLE_W'(800);
   localparam logic [LEVEL_W-1:0]  LEVEL_FULL  = LEVEL_W'(25600);
   localparam int                  LEVEL_PCT   = 100;
   localparam int                  Q8_SHIFT    = 8;

   // Reciprocal constants: floor(x / 3), floor(x / 15) and floor(6 * m / 5).
   localparam int MEAN_PROD_W = 24;
   localparam int MEAN_RECIP  = 2731;
   localparam int MEAN_SHIFT  = 13;
   localparam int AVG_PROD_W  = 29;
   localparam int AVG_RECIP   = 17477;
   localparam int AVG_SHIFT   = 18;
   localparam int THR_PROD_W  = 26;
   localparam int THR_RECIP   = 6 * 6554;
   localparam int THR_SHIFT   = 15;

   localparam int DIVIDEND_W = SAMPLE_W + LEVEL_W;
   localparam int DIV_STEPS  = LEVEL_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef enum logic [1:0] {
      OP_NORMALIZE  = 2'd0,
      OP_SET_MAX    = 2'd1,
      OP_TRACK_PEAK = 2'd2,
      OP_RESERVED   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type      opcode;
      logic [CH_W-1:0] channel;
      sample_type      sample_a;
      sample_type      sample_b;
      sample_type      sample_c;
      sample_type      sample_d;
      sample_type      sample_e;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]    out_channel;
      sample_type         smoothed;
      logic [LEVEL_W-1:0] level_q8;
      sample_type         peak;
   } rsp_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [CH_W-1:0]   channel;
      logic              in_range;
      logic [SUM3_W-1:0] sum3;
   } task_type;

   typedef struct packed {
      logic [HISTORY_DEPTH-2:0][SAMPLE_W-1:0] hist;
      sample_type                             max_val;
   } row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_AVG,
      ST_THR,
      ST_DECIDE,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/icc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner front end
// Accepts a burst, checks its channel and forms the sum of the middle three
// reads, then hands the work entry to the queue.
// ----------------------------------------------------------------------------
module icc_front import icc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output task_type q_entry
);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      sample_type        smp [5];
      sample_type        lo;
      sample_type        hi;
      logic [SUM3_W:0]   sum5;
      smp[0] = req_data.sample_a & SAMPLE_MASK;
      smp[1] = req_data.sample_b & SAMPLE_MASK;
      smp[2] = req_data.sample_c & SAMPLE_MASK;
      smp[3] = req_data.sample_d & SAMPLE_MASK;
      smp[4] = req_data.sample_e & SAMPLE_MASK;
      lo   = smp[0];
      hi   = smp[0];
      sum5 = (SUM3_W+1)'(smp[0]);
      for (int i = 1; i < 5; i++) begin
         if (smp[i] < lo) lo = smp[i];
         if (smp[i] > hi) hi = smp[i];
         sum5 = sum5 + (SUM3_W+1)'(smp[i]);
      end
      q_entry.opcode   = req_data.opcode;
      q_entry.channel  = req_data.channel;
      q_entry.in_range = (32'(req_data.channel) < 32'(CHANNELS));
      q_entry.sum3     = SUM3_W'(sum5 - (SUM3_W+1)'(lo) - (SUM3_W+1)'(hi));
   end

endmodule

@@ hw/rtl/icc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner work queue
// Short FIFO of work entries between the front end and the back end.
// ----------------------------------------------------------------------------
module icc_queue import icc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     pop_valid,
   output task_type pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

   task_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_Q'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ hw/rtl/icc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner back end
// Sequencer that reads the channel row, forms the trimmed mean and weighted
// average, applies the opcode with a serial divider, and writes the row back.
// ----------------------------------------------------------------------------
module icc_back import icc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  task_type q_entry,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam row_type ROW_RESET = '{hist: '0, max_val: MAX_RESET};

   row_type                  mem [CHANNELS];
   row_type                  rd_ff;
   row_type                  wr_row;
   logic                     mem_we;
   logic [IDX_W-1:0]         rd_idx;
   logic [IDX_W+CH_W-1:0]    ch_ext;

   logic [CHANNELS-1:0]      row_valid_ff, row_valid_in;
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   task_type                 task_ff, task_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   row_type                  row_ff, row_in;
   logic [MEAN_PROD_W-1:0]   mean_prod_ff, mean_prod_in;
   sample_type               mean_ff, mean_in;
   logic [AVG_PROD_W-1:0]    avg_prod_ff, avg_prod_in;
   sample_type               avg_ff, avg_in;
   logic [THR_PROD_W-1:0]    thr_prod_ff, thr_prod_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   sample_type               max_new_ff, max_new_in;
   sample_type               rem_ff, rem_in;
   logic [LEVEL_W-1:0]       shf_ff, shf_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   assign ch_ext    = (IDX_W+CH_W)'(q_entry.channel);
   assign rd_idx    = q_entry.in_range ? ch_ext[IDX_W-1:0] : '0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sample_type              mean_val;
      logic [WSUM_W-1:0]       wsum;
      logic [THR_W-1:0]        thr;
      logic [SAMPLE_W+6:0]     avg100;
      logic [DIVIDEND_W-1:0]   dividend;
      logic [SAMPLE_W:0]       cand;
      logic                    ge;

      state_in     = state_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      task_in      = task_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      mean_prod_in = mean_prod_ff;
      mean_in      = mean_ff;
      avg_prod_in  = avg_prod_ff;
      avg_in       = avg_ff;
      thr_prod_in  = thr_prod_ff;
      level_in     = level_ff;
      max_new_in   = max_new_ff;
      rem_in       = rem_ff;
      shf_in       = shf_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;

      mean_val = mean_prod_ff[MEAN_SHIFT+SAMPLE_W-1:MEAN_SHIFT];
      wsum     = WSUM_W'(HISTORY_DEPTH) * WSUM_W'(mean_val);
      for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
         wsum = wsum + WSUM_W'(HISTORY_DEPTH - 1 - k) * WSUM_W'(row_ff.hist[k]);
      end
      thr      = thr_prod_ff[THR_SHIFT+THR_W-1:THR_SHIFT];
      avg100   = (SAMPLE_W+7)'(avg_ff) * (SAMPLE_W+7)'(LEVEL_PCT);
      dividend = DIVIDEND_W'({avg100, Q8_SHIFT'(0)});
      cand     = {rem_ff, shf_ff[LEVEL_W-1]};
      ge       = (cand >= {1'b0, row_ff.max_val});

      wr_row.hist[0] = mean_ff;
      for (int k = 1; k < HISTORY_DEPTH - 1; k++) begin
         wr_row.hist[k] = row_ff.hist[k-1];
      end
      wr_row.max_val = max_new_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               task_in  = q_entry;
               idx_in   = rd_idx;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            row_in       = row_valid_ff[idx_ff] ? rd_ff : ROW_RESET;
            mean_prod_in = MEAN_PROD_W'(task_ff.sum3) * MEAN_PROD_W'(MEAN_RECIP);
            state_in     = ST_AVG;
         end
         ST_AVG: begin
            mean_in     = mean_val;
            avg_prod_in = AVG_PROD_W'(wsum) * AVG_PROD_W'(AVG_RECIP);
            state_in    = ST_THR;
         end
         ST_THR: begin
            avg_in      = avg_prod_ff[AVG_SHIFT+SAMPLE_W-1:AVG_SHIFT];
            thr_prod_in = THR_PROD_W'(row_ff.max_val) * THR_PROD_W'(THR_RECIP);
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            level_in   = '0;
            max_new_in = row_ff.max_val;
            state_in   = ST_DONE;
            if (task_ff.in_range) begin
               case (task_ff.opcode)
                  OP_NORMALIZE: begin
                     if (avg_ff == '0) begin
                        level_in = '0;
                     end else if ({1'b0, avg_ff} >= thr) begin
                        level_in = LEVEL_FULL;
                     end else begin
                        rem_in   = dividend[DIVIDEND_W-1:LEVEL_W];
                        shf_in   = dividend[LEVEL_W-1:0];
                        cnt_in   = CNT_W'(DIV_STEPS - 1);
                        state_in = ST_DIV;
                     end
                  end
                  OP_SET_MAX: begin
                     max_new_in = avg_ff;
                  end
                  OP_TRACK_PEAK: begin
                     if (avg_ff >= row_ff.max_val) max_new_in = avg_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in = ge ? SAMPLE_W'(cand - {1'b0, row_ff.max_val}) : cand[SAMPLE_W-1:0];
            shf_in = {shf_ff[LEVEL_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               level_in = {shf_ff[LEVEL_W-2:0], ge};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_channel = task_ff.channel;
               if (task_ff.in_range) begin
                  rsp_in.smoothed      = avg_ff;
                  rsp_in.level_q8      = level_ff;
                  rsp_in.peak          = max_new_ff;
                  mem_we               = 1'b1;
                  row_valid_in[idx_ff] = 1'b1;
               end else begin
                  rsp_in.smoothed = '0;
                  rsp_in.level_q8 = '0;
                  rsp_in.peak     = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      task_ff      <= task_in;
      idx_ff       <= idx_in;
      row_ff       <= row_in;
      mean_prod_ff <= mean_prod_in;
      mean_ff      <= mean_in;
      avg_prod_ff  <= avg_prod_in;
      avg_ff       <= avg_in;
      thr_prod_ff  <= thr_prod_in;
      level_ff     <= level_in;
      max_new_ff   <= max_new_in;
      rem_ff       <= rem_in;
      shf_ff       <= shf_in;
      cnt_ff       <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= wr_row;
      rd_ff <= mem[rd_idx];
   end

endmodule

@@ hw/rtl/inductor_channel_conditioner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner
// Trimmed mean, per-channel weighted history average and normalization
// against a per-channel maximum for bursts of five ADC reads.
// ----------------------------------------------------------------------------
// A burst enters on the req_ channel as one beat: opcode, channel and five
// raw reads. Each burst gives exactly one beat on the rsp_ channel, in order.
// The front end takes a beat whenever its two-entry queue has room, so the
// sender is held off only while the queue is full.
// The back end works on one burst at a time and pops the next only when it
// is through with the last. Each burst goes through the mean, average,
// threshold and decide states to the done state, which loads the result
// register. A normalize that needs the quotient also goes through the divide
// state, whose serial divider resolves one quotient bit per cycle; a set,
// track or unused opcode, or a channel out of range, skips it.
// The per-channel history and maximum sit in a small memory with one valid
// bit per channel; after reset every channel reads as an empty history and
// a maximum of 800, with no clearing pass.
// When the receiver stalls, the result beat holds in the output register,
// the back end waits with its next result; the queue takes beats until full.
// ----------------------------------------------------------------------------
module inductor_channel_conditioner import icc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     q_push;
   logic     q_full;
   task_type q_entry;
   logic     q_pop;
   logic     q_valid;
   task_type q_head;

   icc_front #(.CHANNELS(CHANNELS)) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   icc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_head)
   );

   icc_back #(.CHANNELS(CHANNELS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/icc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module icc_checker import icc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result beat holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("Stalled result beat changed.");

   // No result beat is offered in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("Result beat offered straight after reset.");

   // A nonzero level needs a nonzero smoothed average.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.level_q8 != '0)) |-> (rsp_data.smoothed != '0))
      else $error("Nonzero level with a zero average.");

   // A channel out of range reports zero in every computed field.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (32'(rsp_data.out_channel) >= 32'(CHANNELS))) |->
      ((rsp_data.smoothed == '0) && (rsp_data.level_q8 == '0) && (rsp_data.peak == '0)))
      else $error("Out-of-range channel reported nonzero fields.");

endmodule

bind inductor_channel_conditioner icc_checker #(.CHANNELS(CHANNELS)) u_icc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ bench/icc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner result checker
// Watches both channels of the conditioner. For every accepted burst it
// predicts the trimmed mean, the per-channel weighted history average and the
// normalized level or maximum update. It keeps the predictions in order and
// compares every accepted result beat with the oldest one, field by field.
// ----------------------------------------------------------------------------
module icc_result_checker import icc_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding,
   output int      compared
);

   sample_type hist_mem [CHANNELS][HISTORY_DEPTH];
   sample_type peak_mem [CHANNELS];
   rsp_type    expected_results [$];

   task automatic report_mismatch(input string field, input int got, input int want);
      if (fail_count < 40) begin
         $display("%0t: result beat %0d, field %s is %0d, predicted %0d",
                  $realtime, compared, field, got, want);
      end
      fail_count++;
   endtask

   function automatic rsp_type predict_result(input req_type burst);
      rsp_type     result;
      int unsigned reads [5];
      int unsigned lo, hi, total, mean, wsum, avg, peak, level;
      int          ch;
      reads[0] = burst.sample_a & SAMPLE_MASK;
      reads[1] = burst.sample_b & SAMPLE_MASK;
      reads[2] = burst.sample_c & SAMPLE_MASK;
      reads[3] = burst.sample_d & SAMPLE_MASK;
      reads[4] = burst.sample_e & SAMPLE_MASK;
      result = '0;
      result.out_channel = burst.channel;
      ch = burst.channel;
      if (ch >= CHANNELS) return result;
      lo = reads[0];
      hi = reads[0];
      total = 0;
      for (int k = 0; k < 5; k++) begin
         total += reads[k];
         if (reads[k] < lo) lo = reads[k];
         if (reads[k] > hi) hi = reads[k];
      end
      mean = (total - lo - hi) / 3;
      for (int k = HISTORY_DEPTH - 1; k > 0; k--) hist_mem[ch][k] = hist_mem[ch][k-1];
      hist_mem[ch][0] = sample_type'(mean);
      wsum = 0;
      for (int k = 0; k < HISTORY_DEPTH; k++) wsum += (HISTORY_DEPTH - k) * hist_mem[ch][k];
      avg   = wsum / 15;
      peak  = peak_mem[ch];
      level = 0;
      case (burst.opcode)
         OP_NORMALIZE: begin
            if (avg == 0) level = 0;
            else if (avg >= (peak * 6) / 5) level = LEVEL_FULL;
            else level = (avg * LEVEL_FULL) / peak;
         end
         OP_SET_MAX: peak_mem[ch] = sample_type'(avg);
         OP_TRACK_PEAK: begin
            if (avg >= peak) peak_mem[ch] = sample_type'(avg);
         end
         default: ;
      endcase
      result.smoothed = sample_type'(avg);
      result.level_q8 = LEVEL_W'(level);
      result.peak     = peak_mem[ch];
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int k = 0; k < HISTORY_DEPTH; k++) hist_mem[c][k] = '0;
            peak_mem[c] = MAX_RESET;
         end
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("beat with nothing pending", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.out_channel !== want.out_channel)
                  report_mismatch("out_channel", rsp_data.out_channel, want.out_channel);
               if (rsp_data.smoothed !== want.smoothed)
                  report_mismatch("smoothed", rsp_data.smoothed, want.smoothed);
               if (rsp_data.level_q8 !== want.level_q8)
                  report_mismatch("level_q8", rsp_data.level_q8, want.level_q8);
               if (rsp_data.peak !== want.peak)
                  report_mismatch("peak", rsp_data.peak, want.peak);
            end
            compared++;
         end
         if (req_valid && req_ready) expected_results.push_back(predict_result(req_data));
      end
      outstanding = expected_results.size();
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inductor channel conditioner testbench
// Drives directed bursts for the corner cases of the conditioner, then
// random bursts shaped to settle channel histories at chosen levels, with
// random idle bursts on the sender and stalls on the receiver. A separate
// checker predicts and compares every result beat; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top import icc_pkg::*; ();

   localparam int RANDOM_BURSTS = 1230;
   localparam int CALM_FROM     = 1080;
   localparam int WATCHDOG      = 2000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int compared;
   int idle_pct     = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;
   int sent         = 0;

   always #6 clock = ~clock;

   inductor_channel_conditioner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   icc_result_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .compared    (compared)
   );

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!reset && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         stall_left <= $urandom_range(8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG);
         $display("[inductor_channel_conditioner] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_burst(input opcode_type op, input int ch, input int a, input int b,
                             input int c, input int d, input int e);
      req_data  <= '{op, CH_W'(ch), sample_type'(a), sample_type'(b), sample_type'(c),
                     sample_type'(d), sample_type'(e)};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
   endtask

   initial begin
      int         base [8];
      int         reads [5];
      int         mode, ch, wild, v, pick;
      opcode_type op;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, every opcode, zero maximum, ties, bad channels.
      send_burst(OP_NORMALIZE, 0, 0, 0, 0, 0, 0);
      send_burst(OP_NORMALIZE, 1, 1023, 1023, 1023, 1023, 1023);
      send_burst(OP_RESERVED, 1, 1023, 1023, 1023, 1023, 1023);
      send_burst(OP_TRACK_PEAK, 1, 1023, 1023, 1023, 1023, 1023);
      send_burst(OP_NORMALIZE, 1, 1023, 1023, 1023, 1023, 1023);
      send_burst(OP_NORMALIZE, 1, 1023, 1023, 1023, 1023, 1023);
      send_burst(OP_SET_MAX, 3, 0, 0, 0, 0, 0);
      send_burst(OP_NORMALIZE, 3, 0, 0, 1023, 1023, 1023);
      send_burst(OP_NORMALIZE, 3, 0, 0, 0, 0, 0);
      send_burst(OP_NORMALIZE, 5, 1023, 1023, 1023, 1023, 1023);
      send_burst(OP_SET_MAX, 6, 1023, 0, 1023, 0, 1023);
      send_burst(OP_TRACK_PEAK, 7, 1023, 1023, 1023, 1023, 1023);
      for (int k = 0; k < 4; k++) send_burst(OP_RESERVED, 4, 600, 600, 600, 600, 600);
      send_burst(OP_SET_MAX, 4, 600, 600, 600, 600, 600);
      send_burst(OP_TRACK_PEAK, 4, 600, 600, 600, 600, 600);
      send_burst(OP_NORMALIZE, 4, 600, 600, 600, 600, 600);
      send_burst(OP_NORMALIZE, 0, 1023, 0, 512, 7, 300);
      send_burst(OP_NORMALIZE, 2, 'h155, 'h2AA, 'h155, 'h2AA, 'h155);

      for (int k = 0; k < 8; k++) base[k] = $urandom_range(1023);
      for (int n = 0; n < RANDOM_BURSTS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(2))
               0: idle_pct = 0;
               1: idle_pct = 15;
               default: idle_pct = 35;
            endcase
         end
         if (n >= CALM_FROM) idle_pct = 0;
         ch = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
         pick = $urandom_range(19);
         if (pick < 10) op = OP_NORMALIZE;
         else if (pick < 13) op = OP_SET_MAX;
         else if (pick < 17) op = OP_TRACK_PEAK;
         else op = OP_RESERVED;
         if ($urandom_range(7) == 0) begin
            if ($urandom_range(3) == 0) base[ch] = $urandom_range(1) ? 1023 : 0;
            else base[ch] = $urandom_range(1023);
         end
         mode = $urandom_range(9);
         wild = $urandom_range(4);
         for (int k = 0; k < 5; k++) begin
            v = base[ch] + int'($urandom_range(40)) - 20;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            if (mode == 6 || mode == 7 || (mode == 9 && k == wild)) v = $urandom_range(1023);
            if (mode == 8) v = $urandom_range(1) ? 1023 : 0;
            reads[k] = v;
         end
         send_burst(op, ch, reads[0], reads[1], reads[2], reads[3], reads[4]);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (40) @(posedge clock);
      $display("Sent %0d bursts over all opcodes and channels 0 to 7; %0d results checked,",
               sent, compared);
      $display("with idle and stall bursts on both channels before a final idle-free stretch.");
      if (outstanding != 0) $display("%0d predicted results never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[inductor_channel_conditioner] OK");
      end else begin
         $display("[inductor_channel_conditioner] ERROR");
      end
      $finish;
   end

endmodule
